// ===== rtl/core/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 validate-and-classify unit.
// Used by the decoder, the classifier and the top level. No dependencies.
package utf8v_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] CpMax          = 21'h10FFFF;
	localparam logic [CpWidth-1:0] SurrogateLo    = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrogateHi    = 21'h00DFFF;
	localparam logic [CpWidth-1:0] MinTwoByte     = 21'h000080;
	localparam logic [CpWidth-1:0] MinThreeByte   = 21'h000800;
	localparam logic [CpWidth-1:0] MinFourByte    = 21'h010000;
	localparam logic [CpWidth-1:0] CpReplacement  = 21'h00FFFD;
	localparam logic [CpWidth-1:0] CpZeroWidthSp  = 21'h00200B;
	localparam logic [CpWidth-1:0] CpByteOrderMk  = 21'h00FEFF;
	localparam logic [CpWidth-1:0] CpC0Last       = 21'h00001F;
	localparam logic [CpWidth-1:0] CpTab          = 21'h000009;
	localparam logic [CpWidth-1:0] CpCr           = 21'h00000D;
	localparam logic [CpWidth-1:0] CpDel          = 21'h00007F;
	localparam logic [CpWidth-1:0] CpC1Last       = 21'h00009F;

	typedef enum logic [1:0] {
		VERDICT_VALID      = 2'd0,
		VERDICT_PENDING    = 2'd1,
		VERDICT_MALFORMED  = 2'd2,
		VERDICT_INCOMPLETE = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		CLASS_ORDINARY    = 2'd0,
		CLASS_REPLACEMENT = 2'd1,
		CLASS_CONTROL     = 2'd2,
		CLASS_FORMAT      = 2'd3
	} point_class_t;

	typedef struct packed {
		logic [1:0]         bytes_left;
		logic [1:0]         sequence_length;
		logic [CpWidth-1:0] accumulator;
		logic               bad_continuation_seen;
		logic               malformed_seen;
		point_class_t       first_class_seen;
	} dec_state_t;

	typedef struct packed {
		verdict_t           verdict;
		logic               point_done;
		logic [CpWidth-1:0] code_point;
		point_class_t       point_class;
		point_class_t       first_bad_class;
		logic               string_done;
	} dec_result_t;

endpackage

// ===== rtl/core/utf8v_classify.sv =====
// Classifier for one finished code point.
// Depends on utf8v_pkg for the code point constants and class codes.
module utf8v_classify import utf8v_pkg::*; (
	input  logic               valid,
	input  logic [CpWidth-1:0] code_point,
	output point_class_t       point_class
);

	always_comb begin
		point_class = CLASS_ORDINARY;
		if (valid) begin
			priority if (code_point == CpReplacement) begin
				point_class = CLASS_REPLACEMENT;
			end else if (code_point <= CpC0Last &&
			             !(code_point >= CpTab && code_point <= CpCr)) begin
				point_class = CLASS_CONTROL;
			end else if (code_point >= CpDel && code_point <= CpC1Last) begin
				point_class = CLASS_CONTROL;
			end else if (code_point == CpZeroWidthSp || code_point == CpByteOrderMk) begin
				point_class = CLASS_FORMAT;
			end else begin
				point_class = CLASS_ORDINARY;
			end
		end
	end

endmodule

// ===== rtl/core/utf8v_decode.sv =====
// Next-state and result logic for one byte of the UTF-8 decoder.
// Depends on utf8v_pkg and instantiates utf8v_classify.
module utf8v_decode import utf8v_pkg::*; (
	input  dec_state_t  cur,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	output dec_state_t  nxt,
	output dec_result_t res
);

	dec_state_t         step;
	dec_state_t         fin;
	logic               done;
	logic [CpWidth-1:0] cp;
	logic [CpWidth-1:0] acc_shift;
	logic [1:0]         left_dec;
	logic               bad_byte;
	logic [CpWidth-1:0] minimum;
	point_class_t       cls;

	assign acc_shift = {cur.accumulator[CpWidth-7:0], data_byte[5:0]};
	assign left_dec  = cur.bytes_left - 2'd1;
	assign bad_byte  = data_byte[7:6] != 2'b10;

	always_comb begin
		unique case (cur.sequence_length)
			2'd1:    minimum = MinTwoByte;
			2'd2:    minimum = MinThreeByte;
			default: minimum = MinFourByte;
		endcase
	end

	always_comb begin
		step = cur;
		done = 1'b0;
		cp   = '0;
		if (!cur.malformed_seen) begin
			if (cur.bytes_left == 2'd0) begin
				step.bad_continuation_seen = 1'b0;
				priority if (!data_byte[7]) begin
					done = 1'b1;
					cp   = {{(CpWidth-8){1'b0}}, data_byte};
				end else if (data_byte[7:5] == 3'b110) begin
					step.bytes_left      = 2'd1;
					step.sequence_length = 2'd1;
					step.accumulator     = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
				end else if (data_byte[7:4] == 4'b1110) begin
					step.bytes_left      = 2'd2;
					step.sequence_length = 2'd2;
					step.accumulator     = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
				end else if (data_byte[7:3] == 5'b11110) begin
					step.bytes_left      = 2'd3;
					step.sequence_length = 2'd3;
					step.accumulator     = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
				end else begin
					step.malformed_seen = 1'b1;
				end
			end else begin
				step.accumulator = acc_shift;
				step.bytes_left  = left_dec;
				if (bad_byte) begin
					step.bad_continuation_seen = 1'b1;
				end
				if (left_dec == 2'd0) begin
					if (cur.bad_continuation_seen || bad_byte || acc_shift < minimum ||
					    acc_shift > CpMax ||
					    (acc_shift >= SurrogateLo && acc_shift <= SurrogateHi)) begin
						step.malformed_seen = 1'b1;
					end else begin
						done = 1'b1;
						cp   = acc_shift;
					end
					step.bad_continuation_seen = 1'b0;
					step.sequence_length       = 2'd0;
					step.accumulator           = '0;
				end
			end
		end
	end

	utf8v_classify u_classify (
		.valid      (done),
		.code_point (cp),
		.point_class(cls)
	);

	always_comb begin
		fin = step;
		if (done && step.first_class_seen == CLASS_ORDINARY) begin
			fin.first_class_seen = cls;
		end
	end

	always_comb begin
		res.point_done      = done;
		res.code_point      = cp;
		res.point_class     = cls;
		res.first_bad_class = fin.first_class_seen;
		res.string_done     = end_of_string;
		priority if (fin.malformed_seen) begin
			res.verdict = VERDICT_MALFORMED;
		end else if (fin.bytes_left != 2'd0) begin
			res.verdict = end_of_string ? VERDICT_INCOMPLETE : VERDICT_PENDING;
		end else begin
			res.verdict = VERDICT_VALID;
		end
	end

	assign nxt = end_of_string ? dec_state_t'('0) : fin;

endmodule

// ===== rtl/core/utf8_validate_and_classify_unit.sv =====
// The result of an accepted input item is written to the output register on the edge that accepts it.
// Throughput: one item per cycle; the decoder state register and the output register
// update on the same edge, and the input side is ready whenever the output register
// is empty or being taken.
// Reset: arst_n clears the decoder state and the output valid flag at once.
// Top level of the UTF-8 validate-and-classify unit; uses utf8v_pkg and utf8v_decode.
module utf8_validate_and_classify_unit import utf8v_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] verdict, [2] point_done, [23:3] code_point,
	                               // [25:24] point_class, [27:26] first_bad_class, zero above
	output logic        m_tlast    // string_done
);

	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	dec_result_t res_q;
	logic        out_valid_q;
	logic        accept;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	utf8v_decode u_decode (
		.cur          (state_q),
		.data_byte    (s_tdata),
		.end_of_string(s_tlast),
		.nxt          (state_nxt),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.string_done;
	assign m_tdata  = {4'b0000, res_q.first_bad_class, res_q.point_class,
	                   res_q.code_point, res_q.point_done, res_q.verdict};

endmodule

// ===== rtl/core/utf8v_checker.sv =====
// Port-level assertions for the UTF-8 validate-and-classify unit, with its bind.
// Depends on utf8_validate_and_classify_unit being present in the design.
module utf8v_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	a_no_point_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[23:3] == 21'd0 && m_tdata[25:24] == 2'd0)
		else $error("result without a code point carries a nonzero point or class");

	a_incomplete_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == 2'd3 |-> m_tlast)
		else $error("incomplete verdict on an item that does not end the string");

	a_class_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25:24] != 2'd0 |-> m_tdata[27:26] != 2'd0)
		else $error("nonordinary class not reflected in the first bad class");

	a_done_means_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
		else $error("finished code point reported with a nonvalid verdict");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result item changed or dropped");

endmodule

bind utf8_validate_and_classify_unit utf8v_checker u_utf8v_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
